// File: rtl/hrp_pkg.sv
`timescale 1ns / 1ps

package hrp_pkg;

    localparam int HRP_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    typedef enum logic [1:0] {
        PH_REQ  = 2'd0,
        PH_HDR  = 2'd1,
        PH_DONE = 2'd2,
        PH_ERR  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        FLD_METHOD  = 2'd0,
        FLD_PATH    = 2'd1,
        FLD_VERSION = 2'd2,
        FLD_BAD     = 2'd3
    } field_t;

    typedef enum logic [2:0] {
        ST_BUSY  = 3'd0,
        ST_RLOK  = 3'd1,
        ST_HLINE = 3'd2,
        ST_DONE  = 3'd3,
        ST_ERROR = 3'd4
    } status_t;

    localparam logic [2:0] METHOD_NONE = 3'd0;
    localparam logic [1:0] VER_UNKNOWN = 2'd0;
    localparam logic [1:0] VER_1_0     = 2'd1;
    localparam logic [1:0] VER_1_1     = 2'd2;

    localparam int NUM_METHODS = 5;

    // method spellings, first character at index 0
    localparam logic [7:0] METHOD_TEXT [0:NUM_METHODS-1][0:7] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00}
    };
    localparam logic [2:0] METHOD_LEN [0:NUM_METHODS-1] = '{3'd3, 3'd4, 3'd4, 3'd3, 3'd6};

    localparam logic [7:0] VERSION_PREFIX [0:7] = '{"H", "T", "T", "P", "/", "1", ".", 8'h00};

    // item as handed from the front end to the parser
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        logic       is_cr;
        logic       is_lf;
    } hrp_item_t;

    typedef struct packed {
        phase_t     phase;
        logic       cr_pending;
        field_t     line_field;
        logic [2:0] method_position;
        logic [4:0] method_candidates;
        logic [3:0] version_position;
        logic       version_match;
        logic       colon_seen;
        logic [2:0] method_code;
        logic [1:0] version_code;
    } hrp_state_t;

    localparam hrp_state_t STATE_RESET = '{
        phase:             PH_REQ,
        cr_pending:        1'b0,
        line_field:        FLD_METHOD,
        method_position:   3'd0,
        method_candidates: 5'b11111,
        version_position:  4'd0,
        version_match:     1'b1,
        colon_seen:        1'b0,
        method_code:       METHOD_NONE,
        version_code:      VER_UNKNOWN
    };

    // one content byte of a line
    function automatic hrp_state_t take_content(input hrp_state_t s, input logic [7:0] b);
        hrp_state_t n;
        logic [2:0] code;
        n    = s;
        code = METHOD_NONE;
        if (s.phase == PH_HDR)
        begin
            if (b == CH_COLON)
                n.colon_seen = 1'b1;
        end
        else if (s.phase == PH_REQ)
        begin
            unique case (s.line_field)
                FLD_METHOD:
                begin
                    if (b == CH_SPACE)
                    begin
                        for (int k = 0; k < NUM_METHODS; k++)
                        begin
                            if (s.method_candidates[k] && METHOD_LEN[k] == s.method_position)
                                code = 3'(k + 1);
                        end
                        n.method_code = code;
                        n.line_field  = (code != METHOD_NONE) ? FLD_PATH : FLD_BAD;
                    end
                    else
                    begin
                        for (int k = 0; k < NUM_METHODS; k++)
                        begin
                            if (s.method_position >= METHOD_LEN[k] ||
                                METHOD_TEXT[k][s.method_position] != b)
                                n.method_candidates[k] = 1'b0;
                        end
                        if (s.method_position < 3'd7)
                            n.method_position = s.method_position + 3'd1;
                    end
                end
                FLD_PATH:
                begin
                    if (b == CH_SPACE)
                    begin
                        n.line_field       = FLD_VERSION;
                        n.version_position = 4'd0;
                        n.version_match    = 1'b1;
                    end
                end
                FLD_VERSION:
                begin
                    if (s.version_position < 4'd7)
                    begin
                        if (VERSION_PREFIX[s.version_position[2:0]] != b)
                            n.version_match = 1'b0;
                    end
                    else if (s.version_position == 4'd7)
                    begin
                        if (b == CH_ONE)
                            n.version_code = VER_1_1;
                        else if (b == CH_ZERO)
                            n.version_code = VER_1_0;
                        else
                            n.version_match = 1'b0;
                    end
                    else
                    begin
                        n.version_match = 1'b0;
                    end
                    if (s.version_position < 4'd9)
                        n.version_position = s.version_position + 4'd1;
                end
                FLD_BAD:
                begin
                    n = s;
                end
            endcase
        end
        return n;
    endfunction

endpackage

// File: rtl/hrp_front.sv
`timescale 1ns / 1ps

module hrp_front
    import hrp_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       q_full,
    output logic       q_push,
    output hrp_item_t  q_item
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // line-break classes are worked out here so the parser sees flags only
    always_comb
    begin
        q_item.data_byte = s_tdata;
        q_item.restart   = s_tuser;
        q_item.is_cr     = (s_tdata == CH_CR);
        q_item.is_lf     = (s_tdata == CH_LF);
    end

endmodule

// File: rtl/hrp_queue.sv
`timescale 1ns / 1ps

module hrp_queue
    import hrp_pkg::*;
#(
    parameter int DEPTH = HRP_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hrp_item_t push_item,
    input  logic      pop,
    output hrp_item_t head_item,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrp_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: rtl/hrp_back.sv
`timescale 1ns / 1ps

module hrp_back
    import hrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  hrp_item_t  q_item,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    hrp_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    hrp_state_t s;
    status_t    status;
    logic [1:0] version_out;

    assign q_pop    = !q_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        s      = q_item.restart ? STATE_RESET : state_reg;
        status = ST_BUSY;
        priority if (s.phase == PH_ERR)
        begin
            status = ST_ERROR;
        end
        else if (s.phase == PH_DONE)
        begin
            status = ST_DONE;
        end
        else if (s.cr_pending && q_item.is_lf)
        begin
            // end of line
            s.cr_pending = 1'b0;
            if (s.phase == PH_REQ)
            begin
                if (s.line_field == FLD_VERSION && s.version_position == 4'd8 &&
                    s.version_match)
                begin
                    s.phase      = PH_HDR;
                    s.colon_seen = 1'b0;
                    status       = ST_RLOK;
                end
                else
                begin
                    s.version_code = VER_UNKNOWN;
                    s.phase        = PH_ERR;
                    status         = ST_ERROR;
                end
            end
            else if (s.colon_seen)
            begin
                s.colon_seen = 1'b0;
                status       = ST_HLINE;
            end
            else
            begin
                s.phase = PH_DONE;
                status  = ST_DONE;
            end
        end
        else
        begin
            // a lone cr is content, taken ahead of this byte
            if (s.cr_pending)
            begin
                s.cr_pending = 1'b0;
                s = take_content(s, CH_CR);
            end
            if (q_item.is_cr)
                s.cr_pending = 1'b1;
            else
                s = take_content(s, q_item.data_byte);
        end

        version_out = (s.phase == PH_REQ) ? VER_UNKNOWN : s.version_code;

        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (q_pop)
        begin
            state_next    = s;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {version_out, s.method_code, status};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // error and completion hold until a restart item
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_ERR && !(q_pop && q_item.restart) |=> state_reg.phase == PH_ERR)
        else $error("error phase left without restart");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_DONE && !(q_pop && q_item.restart) |=> state_reg.phase == PH_DONE)
        else $error("done phase left without restart");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tdata_reg[7:6] != VER_UNKNOWN |-> m_tdata_reg[5:3] != METHOD_NONE)
        else $error("version reported without a method");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tdata_reg[2:0] == ST_RLOK |-> m_tdata_reg[7:6] != VER_UNKNOWN)
        else $error("request line accepted without a version");

endmodule

// File: rtl/http_request_head_parser_unit.sv
`timescale 1ns / 1ps

// channel   dir  tdata                                    tuser
// s_*       in   [7:0] data_byte                          [0] restart
// m_*       out  [2:0] status, [5:3] method, [7:6] version -
//
// one byte per cycle sustained while m_tready holds; a byte taken is queued, then
// popped into the m_tdata register; the parser updates its whole line state per
// byte combinationally, folding a lone cr and the byte after it into that update
// a small queue sits between the input stage and the parser so each side stalls alone
// reset clears the parser, the queue pointers and the output valid flag; no clearing pass
module http_request_head_parser_unit
    import hrp_pkg::*;
#(
    parameter int QUEUE_DEPTH = HRP_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] restart
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [2:0] status, [5:3] method, [7:6] version
);

    hrp_item_t push_item;
    hrp_item_t head_item;
    logic      q_push;
    logic      q_pop;
    logic      q_empty;
    logic      q_full;

    hrp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    hrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    hrp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hrp_pkg::*;

    // one raw byte of the request stream; hold marks a pause until all results are back
    typedef struct {
        logic [7:0] data;
        logic       restart;
        bit         hold;
    } stream_byte_t;

    // packed so that it lines up with m_tdata
    typedef struct packed {
        logic [1:0] version;
        logic [2:0] method;
        status_t    status;
    } parse_result_t;

    localparam int BYTE_TARGET = 1650;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    http_request_head_parser_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stream_byte_t  byte_queue [$];
    parse_result_t predicted_q [$];

    string verb_names [0:4] = '{"GET", "POST", "HEAD", "PUT", "DELETE"};
    string version_head     = "HTTP/1.";

    // predictor state
    phase_t     ph;
    logic       cr_wait;
    field_t     fld;
    logic [2:0] mpos;
    logic [4:0] mcand;
    logic [3:0] vpos;
    logic       vok;
    logic       colon;
    logic [2:0] mcode;
    logic [1:0] vcode;

    // stimulus bookkeeping
    bit           next_restart;
    int           stim_bytes;
    int           bytes_sent;
    int           send_gap;
    bit           send_quiet;
    stream_byte_t next_item;
    int           recv_stall;
    int           recv_draw;
    bit           recv_quiet;
    parse_result_t want;
    int           mismatch_count;
    int           drain_pauses;
    bit           pause_added;
    int           lines_ok;
    int           header_lines;
    int           heads_done;
    int           error_results;

    function automatic void clear_parse();
        ph      = PH_REQ;
        cr_wait = 1'b0;
        fld     = FLD_METHOD;
        mpos    = 3'd0;
        mcand   = 5'b11111;
        vpos    = 4'd0;
        vok     = 1'b1;
        colon   = 1'b0;
        mcode   = METHOD_NONE;
        vcode   = VER_UNKNOWN;
    endfunction

    // one content byte of the current line
    function automatic void eat_byte(input logic [7:0] b);
        logic [2:0] code;
        code = METHOD_NONE;
        if (ph == PH_HDR)
        begin
            if (b == CH_COLON)
                colon = 1'b1;
        end
        else if (ph == PH_REQ)
        begin
            case (fld)
                FLD_METHOD:
                begin
                    if (b == CH_SPACE)
                    begin
                        for (int k = 0; k < 5; k++)
                            if (mcand[k] && verb_names[k].len() == int'(mpos))
                                code = 3'(k + 1);
                        mcode = code;
                        fld   = (code != METHOD_NONE) ? FLD_PATH : FLD_BAD;
                    end
                    else
                    begin
                        for (int k = 0; k < 5; k++)
                        begin
                            if (int'(mpos) >= verb_names[k].len())
                                mcand[k] = 1'b0;
                            else if (verb_names[k][mpos] != b)
                                mcand[k] = 1'b0;
                        end
                        if (mpos < 3'd7)
                            mpos = mpos + 3'd1;
                    end
                end
                FLD_PATH:
                begin
                    if (b == CH_SPACE)
                    begin
                        fld  = FLD_VERSION;
                        vpos = 4'd0;
                        vok  = 1'b1;
                    end
                end
                FLD_VERSION:
                begin
                    if (vpos < 4'd7)
                    begin
                        if (version_head[vpos] != b)
                            vok = 1'b0;
                    end
                    else if (vpos == 4'd7)
                    begin
                        if (b == CH_ONE)
                            vcode = VER_1_1;
                        else if (b == CH_ZERO)
                            vcode = VER_1_0;
                        else
                            vok = 1'b0;
                    end
                    else
                        vok = 1'b0;
                    if (vpos < 4'd9)
                        vpos = vpos + 4'd1;
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    function automatic status_t close_line();
        if (ph == PH_REQ)
        begin
            if (fld == FLD_VERSION && vpos == 4'd8 && vok)
            begin
                ph    = PH_HDR;
                colon = 1'b0;
                return ST_RLOK;
            end
            vcode = VER_UNKNOWN;
            ph    = PH_ERR;
            return ST_ERROR;
        end
        if (colon)
        begin
            colon = 1'b0;
            return ST_HLINE;
        end
        ph = PH_DONE;
        return ST_DONE;
    endfunction

    function automatic parse_result_t parse_byte(input logic [7:0] b, input logic rs);
        parse_result_t r;
        r.status = ST_BUSY;
        if (rs)
            clear_parse();
        if (ph == PH_ERR)
            r.status = ST_ERROR;
        else if (ph == PH_DONE)
            r.status = ST_DONE;
        else if (cr_wait && b == CH_LF)
        begin
            cr_wait  = 1'b0;
            r.status = close_line();
        end
        else
        begin
            // a lone cr turns into content together with the byte after it
            if (cr_wait)
            begin
                cr_wait = 1'b0;
                eat_byte(CH_CR);
            end
            if (b == CH_CR)
                cr_wait = 1'b1;
            else
                eat_byte(b);
        end
        r.method  = mcode;
        r.version = (ph == PH_REQ) ? VER_UNKNOWN : vcode;
        return r;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        stream_byte_t it;
        it.data      = b;
        it.restart   = next_restart;
        it.hold      = 1'b0;
        next_restart = 1'b0;
        byte_queue.push_back(it);
        stim_bytes++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_eol(input bit broken);
        if (broken)
        begin
            if ($urandom_range(0, 1))
                add_byte(CH_LF);
            else
            begin
                add_byte(CH_CR);
                add_byte("x");
            end
        end
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic add_header(input bit with_colon);
        int         n;
        int         pos;
        logic [7:0] c;
        n   = $urandom_range(0, 8);
        pos = $urandom_range(0, n);
        for (int i = 0; i <= n; i++)
        begin
            c = 8'($urandom_range(32, 126));
            if (with_colon && i == pos)
                c = CH_COLON;
            else if (!with_colon && c == CH_COLON)
                c = "-";
            if (with_colon || i < n)
                add_byte(c);
        end
    endtask

    task automatic add_request();
        int         kind;
        string      verb;
        string      ver;
        int         n;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        verb = verb_names[$urandom_range(0, 4)];
        ver  = $urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0";
        if (kind == 0)
        begin
            case ($urandom_range(0, 4))
                0: verb = {verb, "X"};
                1: verb = verb.substr(0, verb.len() - 2);
                2: verb = "DELETEXYZ";
                3: verb = "get";
                default: verb = "";
            endcase
        end
        if (kind == 1)
        begin
            case ($urandom_range(0, 5))
                0: ver = "HTTP/1.2";
                1: ver = "HTTP/1.";
                2: ver = "HTTP/1.10";
                3: ver = "HTTP/2.0";
                4: ver = "HTTP/1.1 ";
                default: ver = "HTTP/1.1xyzw";
            endcase
        end
        next_restart = 1'b1;
        add_text(verb);
        if (kind != 2)
            add_byte(CH_SPACE);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom_range(0, 255));
            add_byte((c == CH_SPACE) ? 8'h2F : c);
        end
        add_byte(CH_SPACE);
        add_text(ver);
        add_eol(kind == 3);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
        begin
            add_header(1'b1);
            add_eol(kind == 4 && i == 0);
        end
        if ($urandom_range(0, 2) != 0)
            add_header(1'b0);
        add_eol(1'b0);
        // trailing bytes are only ignored, so they do not count
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
        stim_bytes -= n;
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            next_restart = ($urandom_range(0, 7) == 0);
            add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_pause();
        stream_byte_t it;
        it.data    = 8'h00;
        it.restart = 1'b0;
        it.hold    = 1'b1;
        byte_queue.push_back(it);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted_q.push_back(parse_byte(s_tdata, s_tuser));
                bytes_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (byte_queue.size() != 0 && byte_queue[0].hold)
                begin
                    s_tvalid <= 1'b0;
                    if (predicted_q.size() == 0)
                    begin
                        void'(byte_queue.pop_front());
                        drain_pauses++;
                    end
                end
                else if (byte_queue.size() != 0)
                begin
                    next_item = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.data;
                    s_tuser  <= next_item.restart;
                    if ($urandom_range(0, 39) == 0)
                        send_quiet = !send_quiet;
                    send_gap <= send_quiet ? 0 : $urandom_range(0, 11);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (predicted_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected item: status %0d method %0d version %0d",
                             $realtime, m_tdata[2:0], m_tdata[5:3], m_tdata[7:6]);
            end
            else
            begin
                want = predicted_q.pop_front();
                case (want.status)
                    ST_RLOK:  lines_ok++;
                    ST_HLINE: header_lines++;
                    ST_DONE:  heads_done++;
                    ST_ERROR: error_results++;
                    default:
                    begin
                    end
                endcase
                if (m_tdata[2:0] !== want.status || m_tdata[5:3] !== want.method ||
                    m_tdata[7:6] !== want.version)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] mismatch: status %0d/%0d method %0d/%0d version %0d/%0d",
                                 $realtime, want.status, m_tdata[2:0], want.method,
                                 m_tdata[5:3], want.version, m_tdata[7:6]);
                end
            end
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            recv_draw = recv_quiet ? 0 : $urandom_range(0, 11);
            recv_stall <= recv_draw;
            m_tready   <= (recv_draw == 0);
        end
        else if (!m_tready)
        begin
            if (recv_stall <= 1)
                m_tready <= 1'b1;
            recv_stall <= recv_stall - 1;
        end
    end

    initial
    begin
        clear_parse();
        // directed: byte extremes, failed request line and held error,
        // a good request line, an empty line ending the head, a byte after it
        next_restart = 1'b1;
        add_byte(8'h00);
        add_byte(8'hFF);
        add_eol(1'b0);
        add_byte("A");
        next_restart = 1'b1;
        add_text("GET / HTTP/1.1");
        add_eol(1'b0);
        add_eol(1'b0);
        add_byte("Z");

        while (stim_bytes < BYTE_TARGET)
        begin
            if ($urandom_range(0, 99) < 85)
                add_request();
            else
                add_noise();
            if (!pause_added && stim_bytes >= BYTE_TARGET / 2)
            begin
                add_pause();
                pause_added = 1'b1;
            end
        end

        wait (rst_n === 1'b1);
        while (byte_queue.size() != 0 || s_tvalid || predicted_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d bytes: %0d request lines ok, %0d header lines, %0d heads complete",
                 bytes_sent, lines_ok, header_lines, heads_done);
        $display("%0d error results, %0d drained pauses, %0d mismatches",
                 error_results, drain_pauses, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
